// File: design/rcld_pkg.sv
package rcld_pkg;

  // Input operation codes.
  typedef enum logic [1:0] {
    OP_BYTE = 2'd0,
    OP_EOL  = 2'd1,
    OP_TICK = 2'd2,
    OP_NONE = 2'd3
  } op_t;

  // Actuator codes of the output writes.
  localparam logic [2:0] ACT_FWD    = 3'd0;
  localparam logic [2:0] ACT_BACK   = 3'd1;
  localparam logic [2:0] ACT_LEFT   = 3'd2;
  localparam logic [2:0] ACT_RIGHT  = 3'd3;
  localparam logic [2:0] ACT_ESC    = 3'd4;
  localparam logic [2:0] ACT_SERVO1 = 3'd5;
  localparam logic [2:0] ACT_SERVO2 = 3'd6;

  // Configuration register indexes.
  localparam logic CFG_TIMEOUT = 1'b0;
  localparam logic CFG_PULSE   = 1'b1;

  localparam logic [15:0] TIMEOUT_RESET = 16'd500;
  localparam logic [11:0] PULSE_RESET   = 12'd1500;
  localparam int          TICK_BITS_DEFAULT = 16;

  // Command queue between the decoder and the write sequencer.
  localparam int QUEUE_DEPTH = 4;
  localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

  // Characters the decoder looks for.
  localparam logic [7:0] CH_F     = 8'h66;
  localparam logic [7:0] CH_B     = 8'h62;
  localparam logic [7:0] CH_S     = 8'h73;
  localparam logic [7:0] CH_L     = 8'h6C;
  localparam logic [7:0] CH_R     = 8'h72;
  localparam logic [7:0] CH_C     = 8'h63;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_PLUS  = 8'h2B;
  localparam logic [7:0] CH_MINUS = 8'h2D;
  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_NINE  = 8'h39;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_TAB   = 8'h09;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_NUL   = 8'h00;

  localparam logic [31:0] MAG_CAP = 32'h8000_0000;
  localparam logic [31:0] POS_MAX = 32'h7FFF_FFFF;

  // Number parser phase.
  typedef enum logic [1:0] {
    PH_SKIP   = 2'd0,
    PH_DIGITS = 2'd1,
    PH_DONE   = 2'd2
  } phase_t;

  // Kind of command handed to the write sequencer.
  typedef enum logic [1:0] {
    CMD_SWITCH   = 2'd0,
    CMD_SET      = 2'd1,
    CMD_FAILSAFE = 2'd2
  } cmd_kind_t;

  // A switch command writes act_a = 0, then act_b = bit_b.
  // A set command writes act_a = value.
  typedef struct packed {
    cmd_kind_t   kind;
    logic [2:0]  act_a;
    logic [2:0]  act_b;
    logic        bit_b;
    logic [31:0] value;
  } cmd_t;

  // Result of looking up a one-byte command.
  typedef struct packed {
    logic       hit;
    logic [2:0] act_a;
    logic [2:0] act_b;
    logic       bit_b;
  } sw_entry_t;

  function automatic sw_entry_t switch_lookup(input logic [7:0] c);
    sw_entry_t e;
    e = '0;
    case (c)
      CH_F: e = '{1'b1, ACT_BACK, ACT_FWD, 1'b1};
      CH_B: e = '{1'b1, ACT_FWD, ACT_BACK, 1'b1};
      CH_S: e = '{1'b1, ACT_FWD, ACT_BACK, 1'b0};
      CH_L: e = '{1'b1, ACT_RIGHT, ACT_LEFT, 1'b1};
      CH_R: e = '{1'b1, ACT_LEFT, ACT_RIGHT, 1'b1};
      CH_C: e = '{1'b1, ACT_LEFT, ACT_RIGHT, 1'b0};
      default: e = '0;
    endcase
    return e;
  endfunction

  // Name table: SERVO1, SERVO2, ESC.
  function automatic logic [4:0] name_size(input logic [1:0] k);
    logic [4:0] n;
    case (k)
      2'd0: n = 5'd6;
      2'd1: n = 5'd6;
      2'd2: n = 5'd3;
      default: n = 5'd0;
    endcase
    return n;
  endfunction

  function automatic logic [7:0] name_char(input logic [1:0] k, input logic [4:0] pos);
    logic [7:0] c;
    c = CH_NUL;
    case (pos)
      5'd0: c = (k == 2'd2) ? 8'h45 : 8'h53;  // E / S
      5'd1: c = (k == 2'd2) ? 8'h53 : 8'h45;  // S / E
      5'd2: c = (k == 2'd2) ? 8'h43 : 8'h52;  // C / R
      5'd3: c = 8'h56;                        // V
      5'd4: c = 8'h4F;                        // O
      5'd5: c = (k == 2'd1) ? 8'h32 : 8'h31;  // 2 / 1
      default: c = CH_NUL;
    endcase
    return c;
  endfunction

endpackage

// File: design/rc_command_line_decoder.sv
// Remote-control command line decoder with a contact-lost watchdog. One input transaction
// (line byte, end of line or millisecond tick) is taken every clock cycle while the
// four-entry command queue has room. End of line turns a one-byte command into two
// switch writes, or a NAME:NUMBER line into one esc or servo write; a tick past the
// timeout yields seven failsafe writes. The write sequencer drives one output
// transaction per cycle while out_stall is low, and in_stall rises only once the queue
// fills behind a failsafe run. Configuration must be written through cfg_write/cfg_index/
// cfg_data only while no transaction is in flight; the block itself does not enforce this.
module rc_command_line_decoder #(
  parameter int TICK_COUNT_BITS = rcld_pkg::TICK_BITS_DEFAULT
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [1:0]         op,
  input  logic [7:0]         char_in,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         actuator,
  output logic signed [31:0] level,
  output logic               last,
  input  logic               cfg_write,
  input  logic               cfg_index,
  input  logic [15:0]        cfg_data
);
  import rcld_pkg::*;

  logic [15:0] timeout_ticks;
  logic [11:0] failsafe_pulse;
  logic        push, pop, full, empty;
  cmd_t        push_cmd, head;

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      timeout_ticks  <= TIMEOUT_RESET;
      failsafe_pulse <= PULSE_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        CFG_TIMEOUT: timeout_ticks  <= cfg_data;
        CFG_PULSE:   failsafe_pulse <= cfg_data[11:0];
        default:     timeout_ticks  <= timeout_ticks;
      endcase
    end
  end

  // Line decoder and watchdog.
  rcld_front #(
    .TICK_COUNT_BITS(TICK_COUNT_BITS)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .op           (op),
    .char_in      (char_in),
    .timeout_ticks(timeout_ticks),
    .queue_full   (full),
    .push         (push),
    .push_cmd     (push_cmd)
  );

  // Command queue.
  rcld_fifo u_fifo (
    .clk     (clk),
    .rst     (rst),
    .push    (push),
    .push_cmd(push_cmd),
    .pop     (pop),
    .full    (full),
    .empty   (empty),
    .head    (head)
  );

  // Write sequencer.
  rcld_back u_back (
    .clk           (clk),
    .rst           (rst),
    .empty         (empty),
    .head          (head),
    .pop           (pop),
    .failsafe_pulse(failsafe_pulse),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .actuator      (actuator),
    .level         (level),
    .last          (last)
  );

endmodule

// File: design/rcld_front.sv
module rcld_front #(
  parameter int TICK_COUNT_BITS = rcld_pkg::TICK_BITS_DEFAULT
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [1:0]        op,
  input  logic [7:0]        char_in,
  input  logic [15:0]       timeout_ticks,
  input  logic              queue_full,
  output logic              push,
  output rcld_pkg::cmd_t    push_cmd
);
  import rcld_pkg::*;

  localparam int CW = (TICK_COUNT_BITS > 16) ? TICK_COUNT_BITS : 16;

  logic [TICK_COUNT_BITS-1:0] elapsed_ticks, elapsed_ticks_next;
  logic [1:0]  byte_count, byte_count_next;
  logic [7:0]  first_char, first_char_next;
  logic        colon_seen, colon_seen_next;
  logic [4:0]  name_pos, name_pos_next;
  logic        name_ended, name_ended_next;
  logic [2:0]  name_candidates, name_candidates_next;
  phase_t      number_phase, number_phase_next;
  logic        number_negative, number_negative_next;
  logic [31:0] number_magnitude, number_magnitude_next;

  logic        accept;
  logic        is_digit, is_space;
  logic [35:0] mag_times_ten;
  logic [31:0] mag_acc;
  logic [31:0] level_value;
  logic [TICK_COUNT_BITS-1:0] elapsed_inc;
  sw_entry_t   sw;

  assign in_stall = queue_full;
  assign accept   = in_valid && !in_stall;

  // Byte classes and the decimal accumulate step, saturating at the cap.
  always_comb begin
    is_digit = (char_in >= CH_ZERO) && (char_in <= CH_NINE);
    is_space = (char_in == CH_SPACE) || ((char_in >= CH_TAB) && (char_in <= CH_CR));
    mag_times_ten = {1'b0, number_magnitude, 3'b000} + {3'b000, number_magnitude, 1'b0}
                  + {32'd0, char_in[3:0]};
    mag_acc = (mag_times_ten > {4'd0, MAG_CAP}) ? MAG_CAP : mag_times_ten[31:0];
    level_value = number_negative ? (32'd0 - number_magnitude)
                : ((number_magnitude >= MAG_CAP) ? POS_MAX : number_magnitude);
    elapsed_inc = (&elapsed_ticks) ? elapsed_ticks : elapsed_ticks + 1'b1;
    sw = switch_lookup(first_char);
  end

  // Line state update and command generation.
  always_comb begin
    elapsed_ticks_next    = elapsed_ticks;
    byte_count_next       = byte_count;
    first_char_next       = first_char;
    colon_seen_next       = colon_seen;
    name_pos_next         = name_pos;
    name_ended_next       = name_ended;
    name_candidates_next  = name_candidates;
    number_phase_next     = number_phase;
    number_negative_next  = number_negative;
    number_magnitude_next = number_magnitude;
    push                  = 1'b0;
    push_cmd              = '0;

    if (accept) begin
      case (op_t'(op))
        OP_BYTE: begin
          if (byte_count == 2'd0) first_char_next = char_in;
          if (byte_count != 2'd2) byte_count_next = byte_count + 2'd1;
          if (colon_seen) begin
            // Number part: atoi style.
            case (number_phase)
              PH_SKIP: begin
                if (is_space) begin
                  number_phase_next = PH_SKIP;
                end else if (char_in == CH_PLUS) begin
                  number_phase_next = PH_DIGITS;
                end else if (char_in == CH_MINUS) begin
                  number_negative_next = 1'b1;
                  number_phase_next    = PH_DIGITS;
                end else if (is_digit) begin
                  number_phase_next     = PH_DIGITS;
                  number_magnitude_next = mag_acc;
                end else begin
                  number_phase_next = PH_DONE;
                end
              end
              PH_DIGITS: begin
                if (is_digit) number_magnitude_next = mag_acc;
                else number_phase_next = PH_DONE;
              end
              default: number_phase_next = number_phase;
            endcase
          end else if (char_in == CH_COLON) begin
            colon_seen_next = 1'b1;
            for (int k = 0; k < 3; k++) begin
              if (name_size(2'(k)) != name_pos) name_candidates_next[k] = 1'b0;
            end
          end else if (!name_ended) begin
            if (char_in == CH_NUL) begin
              name_ended_next = 1'b1;
            end else begin
              for (int k = 0; k < 3; k++) begin
                if ((name_pos >= name_size(2'(k))) || (name_char(2'(k), name_pos) != char_in))
                  name_candidates_next[k] = 1'b0;
              end
              if (name_pos != 5'd31) name_pos_next = name_pos + 5'd1;
            end
          end
        end
        OP_EOL: begin
          if (byte_count != 2'd0) begin
            elapsed_ticks_next = '0;
            if (byte_count == 2'd1) begin
              push           = sw.hit;
              push_cmd.kind  = CMD_SWITCH;
              push_cmd.act_a = sw.act_a;
              push_cmd.act_b = sw.act_b;
              push_cmd.bit_b = sw.bit_b;
            end else if (colon_seen) begin
              push           = |name_candidates;
              push_cmd.kind  = CMD_SET;
              push_cmd.value = level_value;
              push_cmd.act_a = name_candidates[0] ? ACT_SERVO1
                             : (name_candidates[1] ? ACT_SERVO2 : ACT_ESC);
            end
            // Start a fresh line.
            byte_count_next       = 2'd0;
            first_char_next       = '0;
            colon_seen_next       = 1'b0;
            name_pos_next         = '0;
            name_ended_next       = 1'b0;
            name_candidates_next  = 3'b111;
            number_phase_next     = PH_SKIP;
            number_negative_next  = 1'b0;
            number_magnitude_next = '0;
          end
        end
        OP_TICK: begin
          elapsed_ticks_next = elapsed_inc;
          push          = CW'(elapsed_inc) > CW'(timeout_ticks);
          push_cmd.kind = CMD_FAILSAFE;
        end
        default: begin
          push = 1'b0;
        end
      endcase
    end
  end

  // State registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      elapsed_ticks    <= '0;
      byte_count       <= '0;
      first_char       <= '0;
      colon_seen       <= 1'b0;
      name_pos         <= '0;
      name_ended       <= 1'b0;
      name_candidates  <= 3'b111;
      number_phase     <= PH_SKIP;
      number_negative  <= 1'b0;
      number_magnitude <= '0;
    end else begin
      elapsed_ticks    <= elapsed_ticks_next;
      byte_count       <= byte_count_next;
      first_char       <= first_char_next;
      colon_seen       <= colon_seen_next;
      name_pos         <= name_pos_next;
      name_ended       <= name_ended_next;
      name_candidates  <= name_candidates_next;
      number_phase     <= number_phase_next;
      number_negative  <= number_negative_next;
      number_magnitude <= number_magnitude_next;
    end
  end

endmodule

// File: design/rcld_fifo.sv
module rcld_fifo (
  input  logic           clk,
  input  logic           rst,
  input  logic           push,
  input  rcld_pkg::cmd_t push_cmd,
  input  logic           pop,
  output logic           full,
  output logic           empty,
  output rcld_pkg::cmd_t head
);
  import rcld_pkg::*;

  cmd_t              entries [QUEUE_DEPTH];
  logic [QUEUE_AW-1:0] wr_ptr, rd_ptr;
  logic [QUEUE_AW:0]   count;
  logic                do_push, do_pop;

  assign full    = (count == (QUEUE_AW + 1)'(QUEUE_DEPTH));
  assign empty   = (count == '0);
  assign head    = entries[rd_ptr];
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;

  // Command storage.
  always_ff @(posedge clk) begin
    if (do_push) entries[wr_ptr] <= push_cmd;
  end

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) wr_ptr <= wr_ptr + 1'b1;
      if (do_pop) rd_ptr <= rd_ptr + 1'b1;
      if (do_push && !do_pop) count <= count + 1'b1;
      else if (!do_push && do_pop) count <= count - 1'b1;
    end
  end

endmodule

// File: design/rcld_back.sv
module rcld_back (
  input  logic               clk,
  input  logic               rst,
  input  logic               empty,
  input  rcld_pkg::cmd_t     head,
  output logic               pop,
  input  logic [11:0]        failsafe_pulse,
  output logic               out_valid,
  input  logic               out_stall,
  output logic [2:0]         actuator,
  output logic signed [31:0] level,
  output logic               last
);
  import rcld_pkg::*;

  logic [2:0]  step, step_next;
  logic        load;
  logic [2:0]  w_act;
  logic [31:0] w_level;
  logic        w_last;

  // The output register can take a new write when it is empty or being drained.
  assign load = !out_valid || !out_stall;
  assign pop  = load && !empty && w_last;

  // Expand the head command into its current write.
  always_comb begin
    w_act   = head.act_a;
    w_level = '0;
    w_last  = 1'b1;
    case (head.kind)
      CMD_SWITCH: begin
        if (step == 3'd0) begin
          w_act  = head.act_a;
          w_last = 1'b0;
        end else begin
          w_act   = head.act_b;
          w_level = {31'd0, head.bit_b};
        end
      end
      CMD_SET: begin
        w_level = head.value;
      end
      CMD_FAILSAFE: begin
        w_act   = step;
        w_level = (step >= ACT_SERVO1) ? {20'd0, failsafe_pulse} : 32'd0;
        w_last  = (step == ACT_SERVO2);
      end
      default: begin
        w_last = 1'b1;
      end
    endcase
    step_next = w_last ? 3'd0 : step + 3'd1;
  end

  // Write counter and output valid.
  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      out_valid <= 1'b0;
    end else if (load) begin
      out_valid <= !empty;
      if (!empty) step <= step_next;
    end
  end

  // Output payload register.
  always_ff @(posedge clk) begin
    if (load && !empty) begin
      actuator <= w_act;
      level    <= w_level;
      last     <= w_last;
    end
  end

endmodule
